[rtl/uihg_pkg.sv]
// Shared types, constants and checksum helpers for the UDP/IPv4 header generator.
package uihg_pkg;

    localparam int unsigned CfgAddrW = 3;
    localparam int unsigned CfgDataW = 32;
    localparam int unsigned InDataW  = 40;
    localparam int unsigned OutDataW = 112;

    localparam logic [16:0] MaxPayload = 17'd65507;
    localparam logic [16:0] IpUdpHdrLen = 17'd28;
    localparam logic [16:0] UdpHdrLen = 17'd8;
    localparam logic [15:0] TotLenSat = 16'hFFFF;
    localparam logic [15:0] UdpLenSat = 16'd65515;
    localparam logic [15:0] IpVerTos = 16'h4500;
    localparam logic [7:0]  IpTtl = 8'd250;
    localparam logic [7:0]  IpProtoUdp = 8'd17;

    typedef enum logic [CfgAddrW-1:0] {
        CFG_SRC_ADDR     = 3'd0,
        CFG_SRC_PORT     = 3'd1,
        CFG_FIXED_DST    = 3'd2,
        CFG_DST_PORT     = 3'd3,
        CFG_USE_PKT_DST  = 3'd4,
        CFG_UDP_SUM_EN   = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic [31:0] destination_hint;
        logic        has_byte;
        logic        end_of_packet;
        logic [7:0]  payload_byte;
    } t_in_item;

    typedef struct packed {
        logic [16:0] byte_count;
        logic [15:0] running_sum;
        logic [7:0]  pending_high_byte;
        logic        overflow_flag;
        logic [15:0] identification;
        logic [31:0] destination_address;
    } t_snap;

    typedef struct packed {
        logic [15:0] payload_sum;
        logic [15:0] total_length;
        logic [15:0] udp_length;
        logic        too_long;
        logic [15:0] identification;
        logic [31:0] destination_address;
    } t_len;

    typedef struct packed {
        logic [19:0] header_raw;
        logic [19:0] udp_raw;
        logic [15:0] total_length;
        logic [15:0] udp_length;
        logic        too_long;
        logic [15:0] identification;
        logic [31:0] destination_address;
    } t_sums;

    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    function automatic logic [15:0] oc_fold(input logic [19:0] raw);
        logic [16:0] f;
        f = {1'b0, raw[15:0]} + {13'd0, raw[19:16]};
        return f[15:0] + {15'd0, f[16]};
    endfunction

endpackage

[rtl/udp_ipv4_header_generator.sv]
// UDP/IPv4 header generator: byte absorption, length and checksum pipeline.
// A final item's result passes through the s1, s2, s3, s4 and output registers
// after the item is accepted, and can be held back further by m_axis_tready.
// Throughput: one payload byte per cycle unless m_axis_tready holds back the
// pipeline; the byte count and running ones-complement sum are updated in a single stage.
// Synchronous active-low reset clears the pipeline, the packet state and the
// identification counter, and returns the registers to their reset values.
module udp_ipv4_header_generator
    import uihg_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgAddrW-1:0] i_cfg_addr,
    input  logic [CfgDataW-1:0] i_cfg_wdata,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // payload_byte, destination_hint
    input  logic [InDataW-1:0]  s_axis_tdata,
    input  logic                s_axis_tlast,
    // has_byte
    input  logic                s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // total_length, identification, header_checksum, destination_address,
    // udp_length, udp_checksum
    output logic [OutDataW-1:0] m_axis_tdata,
    // too_long
    output logic                m_axis_tuser
);

    logic [31:0] r_src_addr;
    logic [15:0] r_src_port;
    logic [31:0] r_fixed_dst;
    logic [15:0] r_dst_port;
    logic        r_use_pkt_dst;
    logic        r_udp_sum_en;

    logic [16:0] r_count;
    logic [15:0] r_sum;
    logic [7:0]  r_pend;
    logic        r_flag;
    logic [15:0] r_ident;

    logic        r_s1_v;
    t_in_item    r_s1;
    logic        r_s2_v;
    t_snap       r_s2;
    logic        r_s3_v;
    t_len        r_s3;
    logic        r_s4_v;
    t_sums       r_s4;
    logic        r_out_v;
    logic [OutDataW-1:0] r_out_data;
    logic        r_out_tl;

    logic free_out, free4, free3, free2, free1;

    logic [16:0] n_count;
    logic [15:0] n_sum;
    logic [7:0]  n_pend;
    logic        n_flag;
    t_snap       n_s2;
    t_len        n_s3;
    t_sums       n_s4;
    logic [16:0] tot_ext, ulen_ext;
    logic [15:0] hdr_sum, udp_sum, udp_csum;

    assign free_out = !r_out_v || m_axis_tready;
    assign free4    = !r_s4_v || free_out;
    assign free3    = !r_s3_v || free4;
    assign free2    = !r_s2_v || free3;
    assign free1    = !r_s1_v || free2;

    assign s_axis_tready = free1;
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_tl;

    always_comb begin
        n_count = r_count;
        n_sum   = r_sum;
        n_pend  = r_pend;
        n_flag  = r_flag;
        if (r_s1.has_byte) begin
            if (!r_count[0]) begin
                n_pend = r_s1.payload_byte;
            end else begin
                n_sum = oc_add(r_sum, {r_pend, r_s1.payload_byte});
            end
            n_count = r_count + 17'd1;
            if (n_count > MaxPayload) begin
                n_flag = 1'b1;
            end
        end
        n_s2.byte_count          = n_count;
        n_s2.running_sum         = n_sum;
        n_s2.pending_high_byte   = n_pend;
        n_s2.overflow_flag       = n_flag;
        n_s2.identification      = r_ident;
        n_s2.destination_address = r_use_pkt_dst ? r_s1.destination_hint : r_fixed_dst;
    end

    always_comb begin
        tot_ext = r_s2.byte_count + IpUdpHdrLen;
        ulen_ext = r_s2.byte_count + UdpHdrLen;
        n_s3.payload_sum = r_s2.byte_count[0]
            ? oc_add(r_s2.running_sum, {r_s2.pending_high_byte, 8'h00})
            : r_s2.running_sum;
        n_s3.too_long = r_s2.overflow_flag || (r_s2.byte_count > MaxPayload);
        n_s3.total_length = n_s3.too_long ? TotLenSat : tot_ext[15:0];
        n_s3.udp_length   = n_s3.too_long ? UdpLenSat : ulen_ext[15:0];
        n_s3.identification      = r_s2.identification;
        n_s3.destination_address = r_s2.destination_address;
    end

    always_comb begin
        n_s4.header_raw = {4'd0, IpVerTos} + {4'd0, r_s3.total_length}
            + {4'd0, r_s3.identification} + {4'd0, IpTtl, IpProtoUdp}
            + {4'd0, r_src_addr[31:16]} + {4'd0, r_src_addr[15:0]}
            + {4'd0, r_s3.destination_address[31:16]}
            + {4'd0, r_s3.destination_address[15:0]};
        n_s4.udp_raw = {4'd0, r_s3.payload_sum}
            + {4'd0, r_src_addr[31:16]} + {4'd0, r_src_addr[15:0]}
            + {4'd0, r_s3.destination_address[31:16]}
            + {4'd0, r_s3.destination_address[15:0]}
            + {12'd0, IpProtoUdp} + {4'd0, r_s3.udp_length}
            + {4'd0, r_src_port} + {4'd0, r_dst_port} + {4'd0, r_s3.udp_length};
        n_s4.total_length        = r_s3.total_length;
        n_s4.udp_length          = r_s3.udp_length;
        n_s4.too_long            = r_s3.too_long;
        n_s4.identification      = r_s3.identification;
        n_s4.destination_address = r_s3.destination_address;
    end

    always_comb begin
        hdr_sum  = oc_fold(r_s4.header_raw);
        udp_sum  = oc_fold(r_s4.udp_raw);
        udp_csum = r_udp_sum_en ? ~udp_sum : 16'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_addr    <= '0;
            r_src_port    <= '0;
            r_fixed_dst   <= '0;
            r_dst_port    <= '0;
            r_use_pkt_dst <= 1'b0;
            r_udp_sum_en  <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                CFG_SRC_ADDR:    r_src_addr    <= i_cfg_wdata;
                CFG_SRC_PORT:    r_src_port    <= i_cfg_wdata[15:0];
                CFG_FIXED_DST:   r_fixed_dst   <= i_cfg_wdata;
                CFG_DST_PORT:    r_dst_port    <= i_cfg_wdata[15:0];
                CFG_USE_PKT_DST: r_use_pkt_dst <= i_cfg_wdata[0];
                CFG_UDP_SUM_EN:  r_udp_sum_en  <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_s4_v  <= 1'b0;
            r_out_v <= 1'b0;
            r_count <= '0;
            r_sum   <= '0;
            r_pend  <= '0;
            r_flag  <= 1'b0;
            r_ident <= '0;
        end else begin
            if (free1) begin
                r_s1_v <= s_axis_tvalid;
            end
            if (free2) begin
                r_s2_v <= r_s1_v && r_s1.end_of_packet;
            end
            if (r_s1_v && free2) begin
                if (r_s1.end_of_packet) begin
                    r_count <= '0;
                    r_sum   <= '0;
                    r_pend  <= '0;
                    r_flag  <= 1'b0;
                    r_ident <= r_ident + 16'd1;
                end else begin
                    r_count <= n_count;
                    r_sum   <= n_sum;
                    r_pend  <= n_pend;
                    r_flag  <= n_flag;
                end
            end
            if (free3) begin
                r_s3_v <= r_s2_v;
            end
            if (free4) begin
                r_s4_v <= r_s3_v;
            end
            if (free_out) begin
                r_out_v <= r_s4_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (free1) begin
            r_s1.payload_byte     <= s_axis_tdata[7:0];
            r_s1.destination_hint <= s_axis_tdata[39:8];
            r_s1.end_of_packet    <= s_axis_tlast;
            r_s1.has_byte         <= s_axis_tuser;
        end
        if (free2) begin
            r_s2 <= n_s2;
        end
        if (free3) begin
            r_s3 <= n_s3;
        end
        if (free4) begin
            r_s4 <= n_s4;
        end
        if (free_out) begin
            r_out_data <= {udp_csum, r_s4.udp_length, r_s4.destination_address,
                           ~hdr_sum, r_s4.identification, r_s4.total_length};
            r_out_tl   <= r_s4.too_long;
        end
    end

endmodule
